### hdl/opcm_pkg.sv
package opcm_pkg;

  localparam int unsigned CODE_W = 12;
  localparam int unsigned CNT_W  = 11;
  localparam int unsigned IDX_W  = 10;

  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  localparam logic [2:0] ADDR_THRESHOLD  = 3'd0;
  localparam logic [2:0] ADDR_MIN_PERIOD = 3'd4;

  localparam logic [CODE_W-1:0] THRESHOLD_RST  = 12'd2048;
  localparam logic [CNT_W-1:0]  MIN_PERIOD_RST = 11'd10;

  typedef enum logic [4:0] {
    PH_WAIT_LOW = 5'b00001,
    PH_ARMED    = 5'b00010,
    PH_HIGH     = 5'b00100,
    PH_LOW      = 5'b01000,
    PH_FILL     = 5'b10000
  } phase_t;

  typedef struct packed {
    logic [CODE_W-1:0] analog_sample;
    logic              digital_level;
  } in_item_t;

  typedef struct packed {
    logic              captured;
    logic [CODE_W-1:0] sample_value;
    logic              digital_value;
    logic [IDX_W-1:0]  sample_index;
    logic              done_res;
    logic [CNT_W-1:0]  high_count;
    logic [CNT_W-1:0]  low_count;
    logic [CODE_W-1:0] peak_max;
    logic [CODE_W-1:0] trough_min;
  } out_item_t;

  typedef struct packed {
    logic [CODE_W-1:0] threshold;
    logic [CNT_W-1:0]  min_period;
  } cfg_t;

  typedef struct packed {
    phase_t            phase;
    logic [CNT_W-1:0]  fill_cnt;
    logic [CNT_W-1:0]  high_cnt;
    logic [CNT_W-1:0]  low_cnt;
    logic [CODE_W-1:0] run_max;
    logic [CODE_W-1:0] run_min;
  } meas_t;

  function automatic meas_t meas_clear(logic [CODE_W-1:0] min_init);
    meas_t m;
    m.phase    = PH_WAIT_LOW;
    m.fill_cnt = '0;
    m.high_cnt = '0;
    m.low_cnt  = '0;
    m.run_max  = '0;
    m.run_min  = min_init;
    return m;
  endfunction

endpackage

### hdl/one_period_capture_and_measure_top.sv
// One-period capture and measure block.
// Items enter on the in_ channel (valid/ready): one ADC code and one digital
// level per item. Every item gives exactly one result item on the out_
// channel, carrying the capture flag, the record index, the half-period
// counts and the running extremes after that item.
// An accepted item waits in an input register while the phase update runs,
// and the result register is written when the item moves on from it. One
// item is taken every cycle while the receiver keeps out_ready high.
// When the receiver stalls, the result register holds and the input
// register keeps its item; in_ready falls only when both are full.
// The APB port writes threshold at address 0 and min_period at address 4;
// it must be written only while the block is idle.
// Reset clears the measurement, restores the register defaults and empties
// both pipeline registers.
module one_period_capture_and_measure_top import opcm_pkg::*; #(
  parameter int unsigned RECORD_DEPTH = 100,
  parameter int unsigned SAMPLE_BITS  = 12
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_item_t   out_data,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam logic [CODE_W-1:0] SMASK =
    (SAMPLE_BITS >= CODE_W) ? '1 : CODE_W'((1 << SAMPLE_BITS) - 1);
  localparam logic [CNT_W-1:0] DEPTH = CNT_W'(RECORD_DEPTH);

  cfg_t      cfg_r;
  in_item_t  in_data_r;
  logic      in_vld_r;
  out_item_t out_data_r;
  logic      out_vld_r;
  meas_t     meas_r;
  meas_t     meas_nxt;
  out_item_t res_nxt;
  logic      adv;
  logic      cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.threshold  <= THRESHOLD_RST;
      cfg_r.min_period <= MIN_PERIOD_RST;
    end else if (cfg_wr) begin
      if (cfg_paddr[2] == ADDR_MIN_PERIOD[2]) begin
        cfg_r.min_period <= cfg_pwdata[CNT_W-1:0];
      end else begin
        cfg_r.threshold <= cfg_pwdata[CODE_W-1:0];
      end
    end
  end

  always_comb begin
    if (cfg_paddr[2] == ADDR_THRESHOLD[2]) begin
      cfg_prdata = {{(32-CODE_W){1'b0}}, cfg_r.threshold};
    end else begin
      cfg_prdata = {{(32-CNT_W){1'b0}}, cfg_r.min_period};
    end
  end

  assign adv      = in_vld_r & (~out_vld_r | out_ready);
  assign in_ready = ~in_vld_r | adv;

  opcm_step #(
    .RECORD_DEPTH(RECORD_DEPTH),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_step (
    .cur (meas_r),
    .item(in_data_r),
    .cfg (cfg_r),
    .nxt (meas_nxt),
    .res (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
      meas_r    <= meas_clear(SMASK);
    end else begin
      if (in_ready) begin
        in_vld_r <= in_valid;
      end
      if (adv) begin
        out_vld_r <= 1'b1;
        meas_r    <= meas_nxt;
      end else if (out_ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_data_r <= in_data;
    end
    if (adv) begin
      out_data_r <= res_nxt;
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_data_r;

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    meas_r.fill_cnt <= DEPTH)
    else $error("fill count beyond record depth");

  a_full_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && meas_r.fill_cnt == DEPTH) |=> $stable(meas_r))
    else $error("measurement changed after record was full");

  a_idle_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (meas_r.phase == PH_WAIT_LOW || meas_r.phase == PH_ARMED) |->
      (meas_r.fill_cnt == '0 && meas_r.high_cnt == '0 && meas_r.low_cnt == '0))
    else $error("counts not clear before capture");

  a_index_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && out_data_r.captured) |->
      ({1'b0, out_data_r.sample_index} < DEPTH))
    else $error("captured index beyond record depth");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && !out_ready) |=> (out_vld_r && $stable(out_data_r)))
    else $error("stalled result lost");

endmodule

### hdl/opcm_step.sv
module opcm_step import opcm_pkg::*; #(
  parameter int unsigned RECORD_DEPTH = 100,
  parameter int unsigned SAMPLE_BITS  = 12
) (
  input  meas_t     cur,
  input  in_item_t  item,
  input  cfg_t      cfg,
  output meas_t     nxt,
  output out_item_t res
);

  localparam logic [CODE_W-1:0] SMASK =
    (SAMPLE_BITS >= CODE_W) ? '1 : CODE_W'((1 << SAMPLE_BITS) - 1);
  localparam logic [CNT_W-1:0] DEPTH = CNT_W'(RECORD_DEPTH);

  logic [CODE_W-1:0] s;
  logic              s_low;
  logic [CNT_W-1:0]  high_inc;
  logic [CNT_W-1:0]  low_inc;
  logic [CODE_W-1:0] max_upd;
  logic [CODE_W-1:0] min_upd;
  logic [CNT_W:0]    period;
  logic              cap;

  assign s        = item.analog_sample & SMASK;
  assign s_low    = s < cfg.threshold;
  assign high_inc = (cur.high_cnt == CNT_MAX) ? CNT_MAX : cur.high_cnt + 1'b1;
  assign low_inc  = (cur.low_cnt == CNT_MAX) ? CNT_MAX : cur.low_cnt + 1'b1;
  assign max_upd  = (s > cur.run_max) ? s : cur.run_max;
  assign min_upd  = (s < cur.run_min) ? s : cur.run_min;
  assign period   = {1'b0, cur.high_cnt} + {1'b0, cur.low_cnt};

  always_comb begin
    nxt = cur;
    cap = 1'b0;
    if (cur.fill_cnt < DEPTH) begin
      unique case (cur.phase)
        PH_WAIT_LOW: begin
          if (s_low) begin
            nxt.phase = PH_ARMED;
          end
        end
        PH_ARMED: begin
          if (!s_low) begin
            nxt.phase    = PH_HIGH;
            cap          = 1'b1;
            nxt.high_cnt = high_inc;
            nxt.run_max  = max_upd;
          end
        end
        PH_HIGH: begin
          cap = 1'b1;
          if (!s_low) begin
            nxt.high_cnt = high_inc;
            nxt.run_max  = max_upd;
          end else begin
            nxt.phase   = PH_LOW;
            nxt.low_cnt = low_inc;
            nxt.run_min = min_upd;
          end
        end
        PH_LOW: begin
          if (s_low) begin
            cap         = 1'b1;
            nxt.low_cnt = low_inc;
            nxt.run_min = min_upd;
          end else if (period < {1'b0, cfg.min_period}) begin
            nxt = meas_clear(SMASK);
          end else begin
            nxt.phase = PH_FILL;
            cap       = 1'b1;
          end
        end
        default: begin
          nxt.phase = PH_FILL;
          cap       = 1'b1;
        end
      endcase
      if (cap) begin
        nxt.fill_cnt = cur.fill_cnt + 1'b1;
      end
    end
  end

  always_comb begin
    res.captured      = cap;
    res.sample_value  = cap ? s : '0;
    res.digital_value = cap & item.digital_level;
    res.sample_index  = cap ? cur.fill_cnt[IDX_W-1:0] : '0;
    res.done_res      = nxt.fill_cnt >= DEPTH;
    res.high_count    = nxt.high_cnt;
    res.low_count     = nxt.low_cnt;
    res.peak_max      = nxt.run_max;
    res.trough_min    = nxt.run_min;
  end

endmodule
